// File: design/gcesf_pkg.sv
`timescale 1ns / 1ps
// Package for the grid cell exposed-side finder.
// Holds the request and response beat types, request and status codes, and side bits.
// No dependencies.
package gcesf_pkg;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_LOADED = 2'd2;

    localparam int SIDE_UP    = 0;
    localparam int SIDE_LEFT  = 1;
    localparam int SIDE_DOWN  = 2;
    localparam int SIDE_RIGHT = 3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic [7:0]         query_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         open_mask;
        logic signed [15:0] found_x;
        logic signed [15:0] found_y;
        logic [8:0]         stored_count;
    } out_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// File: design/gcesf_cell_mem.sv
`timescale 1ns / 1ps
// Cell store: one write port and one read port with registered read data.
// Depends on gcesf_pkg for the port control struct.
module gcesf_cell_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                clk,
    input  gcesf_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [31:0]         wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [31:0]         rd_data
);
    import gcesf_pkg::*;

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/gcesf_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: cell count, store writes, and the query scan over the cell store.
// Depends on gcesf_pkg; drives the port of gcesf_cell_mem.
module gcesf_ctrl #(
    parameter int MAX_CELLS = 256,
    parameter int AW        = 8,
    parameter int CW        = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gcesf_pkg::in_item_t  in_item,
    output gcesf_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]        wr_addr,
    output logic [31:0]          wr_data,
    output logic [AW-1:0]        rd_addr,
    input  logic [31:0]          rd_data,
    output logic                 res_valid,
    input  logic                 res_take,
    output gcesf_pkg::out_item_t res_item
);
    import gcesf_pkg::*;

    localparam int XW = (CW > 8) ? CW : 8;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TGT  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]         state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      j_reg;
    logic               cmp_vld_reg;
    logic               res_valid_reg;
    logic [AW-1:0]      tgt_addr_reg;
    logic [AW-1:0]      cmp_addr_reg;
    logic signed [15:0] tx_reg;
    logic signed [15:0] ty_reg;
    logic [3:0]         mask_reg;
    out_item_t          res_item_reg;

    logic               accept;
    logic               full;
    logic               loaded;
    logic               issue;
    logic [CW-1:0]      count_after;
    logic [CW+8:0]      after_ext;
    logic [CW+8:0]      count_ext;
    logic [1:0]         status_now;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [16:0]        dx;
    logic [16:0]        dy;
    logic               same_x;
    logic               same_y;
    logic [3:0]         clr;

    assign in_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(MAX_CELLS));
    assign loaded   = XW'(in_item.query_index) < XW'(count_reg);
    assign issue    = j_reg < count_reg;

    assign rx     = rd_data[31:16];
    assign ry     = rd_data[15:0];
    assign dx     = {rx[15], rx} - {tx_reg[15], tx_reg};
    assign dy     = {ry[15], ry} - {ty_reg[15], ty_reg};
    assign same_x = (rx == tx_reg);
    assign same_y = (ry == ty_reg);

    always_comb
    begin
        clr             = '0;
        clr[SIDE_UP]    = same_x && (dy == 17'd1);
        clr[SIDE_DOWN]  = same_x && (dy == {17{1'b1}});
        clr[SIDE_RIGHT] = same_y && (dx == 17'd1);
        clr[SIDE_LEFT]  = same_y && (dx == {17{1'b1}});
    end

    always_comb
    begin
        count_after = count_reg;
        status_now  = ST_OK;
        unique case (in_item.req_type)
            REQ_CLEAR:
            begin
                count_after = '0;
            end
            REQ_ADD:
            begin
                if (full)
                begin
                    status_now = ST_FULL;
                end
                else
                begin
                    count_after = count_reg + CW'(1);
                end
            end
            REQ_QUERY:
            begin
                if (!loaded)
                begin
                    status_now = ST_NOT_LOADED;
                end
            end
            default:
            begin
                status_now = ST_OK;
            end
        endcase
        after_ext = {9'd0, count_after};
        count_ext = {9'd0, count_reg};
    end

    always_comb
    begin
        mem_ctl = '0;
        wr_addr = count_reg[AW-1:0];
        wr_data = {in_item.cell_x, in_item.cell_y};
        rd_addr = j_reg[AW-1:0];
        if (state_reg == S_IDLE)
        begin
            rd_addr = AW'(in_item.query_index);
        end
        if (accept && (in_item.req_type == REQ_ADD) && !full)
        begin
            mem_ctl.wr_en = 1'b1;
        end
        if (accept && (in_item.req_type == REQ_QUERY) && loaded)
        begin
            mem_ctl.rd_en = 1'b1;
        end
        if ((state_reg == S_SCAN) && issue)
        begin
            mem_ctl.rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            j_reg         <= '0;
            cmp_vld_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_after;
                        if ((in_item.req_type == REQ_QUERY) && loaded)
                        begin
                            state_reg <= S_TGT;
                        end
                        else
                        begin
                            res_valid_reg <= 1'b1;
                        end
                    end
                end
                S_TGT:
                begin
                    j_reg       <= '0;
                    cmp_vld_reg <= 1'b0;
                    state_reg   <= S_SCAN;
                end
                S_SCAN:
                begin
                    cmp_vld_reg <= issue;
                    if (issue)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                    if (!cmp_vld_reg && !issue)
                    begin
                        state_reg     <= S_IDLE;
                        res_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tgt_addr_reg              <= AW'(in_item.query_index);
            res_item_reg.status       <= status_now;
            res_item_reg.open_mask    <= '0;
            res_item_reg.found_x      <= '0;
            res_item_reg.found_y      <= '0;
            res_item_reg.stored_count <= after_ext[8:0];
        end
        if (state_reg == S_TGT)
        begin
            tx_reg   <= rd_data[31:16];
            ty_reg   <= rd_data[15:0];
            mask_reg <= 4'hF;
        end
        if (state_reg == S_SCAN)
        begin
            cmp_addr_reg <= j_reg[AW-1:0];
            if (cmp_vld_reg && (cmp_addr_reg != tgt_addr_reg))
            begin
                mask_reg <= mask_reg & ~clr;
            end
            if (!cmp_vld_reg && !issue)
            begin
                res_item_reg.status       <= ST_OK;
                res_item_reg.open_mask    <= mask_reg;
                res_item_reg.found_x      <= tx_reg;
                res_item_reg.found_y      <= ty_reg;
                res_item_reg.stored_count <= count_ext[8:0];
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// File: design/grid_cell_exposed_side_finder.sv
`timescale 1ns / 1ps
// Top level of the grid cell exposed-side finder with its output register.
// Depends on gcesf_pkg, gcesf_cell_mem and gcesf_ctrl.
//
// Requests arrive on the in channel (in_valid, in_ready, in_item) and each
// produces exactly one response beat on the out channel (out_valid,
// out_ready, out_item). Requests are handled one at a time.
// Clear, add, an unused request type and a query of an index that is not
// loaded pass their response through the internal slot to the output register.
// A valid query reads its own cell from the store and then every stored cell,
// one per cycle through the single read port, and once the scan ends its response
// takes the same path through the internal slot to the output register.
// A response waits in the output register while the receiver stalls; the
// next request is still taken and its response is held in an internal slot,
// after which in_ready stays low until that slot drains.
// Reset empties the cell set and both response slots; stored cells keep no
// reset value and are only read below the current count.
module grid_cell_exposed_side_finder #(
    parameter int MAX_CELLS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gcesf_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gcesf_pkg::out_item_t out_item
);
    import gcesf_pkg::*;

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = $clog2(MAX_CELLS + 1);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          res_valid;
    logic          res_take;
    out_item_t     res_item;
    logic          out_valid_reg;
    out_item_t     out_item_reg;

    gcesf_cell_mem #(
        .DEPTH (MAX_CELLS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gcesf_ctrl #(
        .MAX_CELLS (MAX_CELLS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_item  (res_item)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_item_reg <= res_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_accept_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !res_valid)
        else $error("request taken while a response is pending");

    a_slot_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(res_item)))
        else $error("pending response lost or changed");

    a_error_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status != ST_OK)) |-> (out_item.open_mask == 4'd0))
        else $error("error response carries an open mask");

    a_error_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status != ST_OK))
            |-> ((out_item.found_x == 16'sd0) && (out_item.found_y == 16'sd0)))
        else $error("error response carries a cell");
`endif

endmodule
